// File: rtl/core/gct_pkg.sv
package gct_pkg;

   // Width of slot, base and bank-size arithmetic. Saturated counts stay at or
   // below 31, so the largest slot is 4*31+31+31+1+127; the bank size is capped at TIMER_SLOTS.
   localparam int CALC_W    = 11;
   localparam int CNT_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int SECS_W    = 16;

   localparam logic [2:0] KIND_START = 3'd0;
   localparam logic [2:0] KIND_STOP  = 3'd1;
   localparam logic [2:0] KIND_PAUSE = 3'd2;
   localparam logic [2:0] KIND_SET   = 3'd3;
   localparam logic [2:0] KIND_CHECK = 3'd4;
   localparam logic [2:0] KIND_TICK  = 3'd5;

   localparam logic [2:0] GRP_REC_MOTION = 3'd0;
   localparam logic [2:0] GRP_REC_SENSOR = 3'd1;
   localparam logic [2:0] GRP_MOTION     = 3'd2;
   localparam logic [2:0] GRP_VIDEO_LOSS = 3'd3;
   localparam logic [2:0] GRP_SENSOR_IN  = 3'd4;
   localparam logic [2:0] GRP_SENSOR_OUT = 3'd5;
   localparam logic [2:0] GRP_BUZZER     = 3'd6;
   localparam logic [2:0] GRP_OTHER      = 3'd7;

   localparam logic [CSR_IDX_W-1:0] REG_VIDEO      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SENSOR_IN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SENSOR_OUT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OTHER      = 2'd3;

   localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_COUNTING = 2'd1;
   localparam logic [1:0] ST_PAUSED   = 2'd2;
   localparam logic [1:0] ST_EXPIRED  = 2'd3;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_STATE = 2'd2;

   typedef enum logic [2:0] {
      OP_START,
      OP_STOP,
      OP_PAUSE,
      OP_SET,
      OP_CHECK,
      OP_TICK,
      OP_NOP,
      OP_RANGE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                in_range;
      logic [CALC_W-1:0]   slot;
      logic [CALC_W-1:0]   size;
      logic [SECS_W-1:0]   seconds;
   } cmd_type;

   typedef struct packed {
      logic [1:0]          timer_status;
      logic [SECS_W-1:0]   remaining;
      logic [1:0]          error_code;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]    video;
      logic [CNT_W-1:0]    sensor_in;
      logic [CNT_W-1:0]    sensor_out;
      logic [CNT_W-1:0]    other;
   } cfg_type;

   typedef struct packed {
      logic                clearing;
      logic                walking;
   } back_stat_type;

endpackage

// File: rtl/core/gct_queue.sv
module gct_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (level_ff == LVL_W'(DEPTH));
   assign empty   = (level_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/core/gct_front.sv
module gct_front import gct_pkg::*; #(
   parameter int TIMER_SLOTS  = 128,
   parameter int MAX_CHANNELS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [2:0]        kind,
   input  logic [2:0]        timer_group,
   input  logic [6:0]        channel,
   input  logic [SECS_W-1:0] seconds,
   input  cfg_type           cfg,
   input  logic              clearing,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output cmd_type           cmd
);

   // A 5-bit count never exceeds 31, so a larger cap means no saturation.
   localparam int SAT_CAP = (MAX_CHANNELS > 31) ? 31 : MAX_CHANNELS;

   logic [CALC_W-1:0] v, si, so, oa;
   logic [CALC_W-1:0] base, slot, total, size;
   logic              in_range;
   cmd_type           cmd_new;
   logic              q_full, q_empty;
   logic [$bits(cmd_type)-1:0] q_rdata;

   function automatic logic [CALC_W-1:0] sat_count(input logic [CNT_W-1:0] c);
      sat_count = (c > CNT_W'(SAT_CAP)) ? CALC_W'(SAT_CAP) : CALC_W'(c);
   endfunction

   always_comb begin
      v  = sat_count(cfg.video);
      si = sat_count(cfg.sensor_in);
      so = sat_count(cfg.sensor_out);
      oa = sat_count(cfg.other);

      // The buzzer group shares the sensor-out base; one slot is reserved
      // between sensor-out and the other-alarm group.
      case (timer_group)
         GRP_REC_MOTION: base = '0;
         GRP_REC_SENSOR: base = v;
         GRP_MOTION:     base = v << 1;
         GRP_VIDEO_LOSS: base = (v << 1) + v;
         GRP_SENSOR_IN:  base = v << 2;
         GRP_SENSOR_OUT: base = (v << 2) + si;
         GRP_BUZZER:     base = (v << 2) + si;
         default:        base = (v << 2) + si + so + CALC_W'(1);
      endcase

      total    = (v << 2) + si + so + CALC_W'(1) + oa;
      size     = (total > CALC_W'(TIMER_SLOTS)) ? CALC_W'(TIMER_SLOTS) : total;
      slot     = base + CALC_W'(channel);
      in_range = (slot < size);

      case (kind)
         KIND_START: cmd_new.op = OP_START;
         KIND_STOP:  cmd_new.op = OP_STOP;
         KIND_PAUSE: cmd_new.op = OP_PAUSE;
         KIND_SET:   cmd_new.op = OP_SET;
         KIND_CHECK: cmd_new.op = OP_CHECK;
         KIND_TICK:  cmd_new.op = OP_TICK;
         default:    cmd_new.op = OP_NOP;
      endcase
      if (!in_range && !(cmd_new.op inside {OP_TICK, OP_NOP})) begin
         cmd_new.op = OP_RANGE;
      end
      cmd_new.in_range = in_range;
      cmd_new.slot     = slot;
      cmd_new.size     = size;
      cmd_new.seconds  = seconds;
   end

   // No request is taken while the back end sweeps the store after reset.
   assign full      = q_full || clearing;
   assign cmd_valid = !q_empty;
   assign cmd       = cmd_type'(q_rdata);

   gct_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push && !full),
      .wdata (cmd_new),
      .full  (q_full),
      .pop   (cmd_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

endmodule

// File: rtl/core/gct_back.sv
module gct_back import gct_pkg::*; #(
   parameter int TIMER_SLOTS = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   output logic          cmd_pop,
   input  cmd_type       cmd,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output rsp_type       rsp,
   output back_stat_type stat
);

   localparam int IDX_W = $clog2(TIMER_SLOTS);
   localparam int ENT_W = 2 + SECS_W;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_CMD   = 4'b0100,
      S_TICK  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [ENT_W-1:0]  mem [TIMER_SLOTS];
   logic [ENT_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic              wr_en;
   logic [IDX_W-1:0]  walk_ff, walk_in;
   cmd_type           cur_ff, cur_in;
   logic [1:0]        hit_status_ff, hit_status_in;
   logic [SECS_W-1:0] hit_time_ff, hit_time_in;
   logic [1:0]        old_status, new_status;
   logic [SECS_W-1:0] old_time, new_time;
   logic [1:0]        err;
   logic              walk_last, walk_hit;
   rsp_type           rsp_new;
   logic              rsp_push, rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_rdata;

   always_comb begin
      old_status    = rd_data_ff[ENT_W-1 -: 2];
      old_time      = rd_data_ff[SECS_W-1:0];
      new_status    = old_status;
      new_time      = old_time;
      err           = ERR_OK;
      walk_last     = (CALC_W'(walk_ff) == cur_ff.size - CALC_W'(1));
      walk_hit      = (CALC_W'(walk_ff) == cur_ff.slot);
      state_in      = state_ff;
      walk_in       = walk_ff;
      cur_in        = cur_ff;
      hit_status_in = hit_status_ff;
      hit_time_in   = hit_time_ff;
      rd_addr       = '0;
      wr_addr       = walk_ff;
      wr_data       = '0;
      wr_en         = 1'b0;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp_new       = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            walk_in = walk_ff + 1'b1;
            if (walk_ff == IDX_W'(TIMER_SLOTS - 1)) begin
               walk_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // A command starts only when its result has a place to go.
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               case (cmd.op)
                  OP_NOP: begin
                     rsp_push = 1'b1;
                  end
                  OP_RANGE: begin
                     rsp_push           = 1'b1;
                     rsp_new.error_code = ERR_RANGE;
                  end
                  OP_TICK: begin
                     walk_in       = '0;
                     hit_status_in = ST_IDLE;
                     hit_time_in   = '0;
                     state_in      = S_TICK;
                  end
                  default: begin
                     rd_addr  = cmd.slot[IDX_W-1:0];
                     state_in = S_CMD;
                  end
               endcase
            end
         end
         S_CMD: begin
            case (cur_ff.op)
               OP_START: begin
                  if (old_status != ST_IDLE) begin
                     err = ERR_STATE;
                  end else begin
                     new_status = ST_COUNTING;
                     new_time   = cur_ff.seconds;
                  end
               end
               OP_STOP: begin
                  if (old_status == ST_IDLE) begin
                     err = ERR_STATE;
                  end else begin
                     new_status = ST_IDLE;
                     new_time   = '0;
                  end
               end
               OP_PAUSE: begin
                  if (old_status == ST_IDLE) begin
                     err = ERR_STATE;
                  end else begin
                     new_status = ST_PAUSED;
                  end
               end
               OP_SET: begin
                  new_time = cur_ff.seconds;
               end
               default: begin
               end
            endcase
            wr_en                = (err == ERR_OK);
            wr_addr              = cur_ff.slot[IDX_W-1:0];
            wr_data              = {new_status, new_time};
            rsp_push             = 1'b1;
            rsp_new.timer_status = new_status;
            rsp_new.remaining    = new_time;
            rsp_new.error_code   = err;
            state_in             = S_IDLE;
         end
         S_TICK: begin
            // The entry read in the previous cycle is updated and written back
            // while the next one is read.
            if (old_time != '0 && old_status != ST_PAUSED) begin
               new_time = old_time - 1'b1;
            end
            if (new_time == '0 && old_status == ST_COUNTING) begin
               new_status = ST_EXPIRED;
            end
            wr_en   = 1'b1;
            wr_data = {new_status, new_time};
            rd_addr = walk_last ? '0 : walk_ff + 1'b1;
            walk_in = walk_ff + 1'b1;
            if (walk_hit) begin
               hit_status_in = new_status;
               hit_time_in   = new_time;
            end
            if (walk_last) begin
               rsp_push = 1'b1;
               if (cur_ff.in_range) begin
                  rsp_new.timer_status = walk_hit ? new_status : hit_status_ff;
                  rsp_new.remaining    = walk_hit ? new_time : hit_time_ff;
               end
               walk_in  = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            walk_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         walk_ff  <= '0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      hit_status_ff <= hit_status_in;
      hit_time_ff   <= hit_time_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign stat.clearing = (state_ff == S_CLEAR);
   assign stat.walking  = (state_ff == S_TICK);
   assign rsp           = rsp_type'(rsp_rdata);

   gct_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_new),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .empty (rsp_empty)
   );

endmodule

// File: rtl/core/grouped_countdown_timer_bank.sv
// Bank of TIMER_SLOTS 16-bit countdown timers, addressed as group base plus channel.
// Requests enter through req_push/req_full with kind, timer_group, channel and
// seconds; every accepted request yields exactly one response on the rsp_ side,
// held while rsp_empty is low and taken with rsp_pop.
// Group sizes are set through the csr_ write port (csr_ready is always high);
// write them only while no request is outstanding.
// With the back end free, a start, stop, pause, set-time or check request first
// leaves the command queue while its slot is read from the store, then updates
// the slot and queues its response.
// A tick walks the store one slot per cycle through its single write port, up
// to the bank size, and queues its response after the last slot. Out-of-range
// requests other than ticks, and unused kinds, are answered without a store read.
// The back end takes no new command until the current one is done; it takes
// out-of-range or unused ones every cycle while the response queue has room.
// Up to two requests wait in the command queue and two responses in the
// response queue; when the receiver stalls, req_full rises once both fill.
// After reset the store is swept to idle with zero time, one slot per cycle,
// over all TIMER_SLOTS slots; req_full stays high during the sweep.
module grouped_countdown_timer_bank import gct_pkg::*; #(
   parameter int TIMER_SLOTS  = 128,
   parameter int MAX_CHANNELS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [2:0]           req_kind,
   input  logic [2:0]           req_timer_group,
   input  logic [6:0]           req_channel,
   input  logic [SECS_W-1:0]    req_seconds,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_timer_status,
   output logic [SECS_W-1:0]    rsp_remaining,
   output logic [1:0]           rsp_error_code,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   logic          cmd_valid, cmd_pop;
   cmd_type       cmd;
   rsp_type       rsp;
   back_stat_type back_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_VIDEO:      cfg_in.video      = csr_wdata;
            REG_SENSOR_IN:  cfg_in.sensor_in  = csr_wdata;
            REG_SENSOR_OUT: cfg_in.sensor_out = csr_wdata;
            REG_OTHER:      cfg_in.other      = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {CNT_RESET, CNT_RESET, CNT_RESET, CNT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gct_front #(
      .TIMER_SLOTS  (TIMER_SLOTS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .kind        (req_kind),
      .timer_group (req_timer_group),
      .channel     (req_channel),
      .seconds     (req_seconds),
      .cfg         (cfg_ff),
      .clearing    (back_stat.clearing),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd         (cmd)
   );

   gct_back #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp),
      .stat      (back_stat)
   );

   assign rsp_timer_status = rsp.timer_status;
   assign rsp_remaining    = rsp.remaining;
   assign rsp_error_code   = rsp.error_code;

   a_sweep_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      back_stat.clearing |-> req_full)
      else $error("request accepted during the store sweep");

   a_tick_holds_queue: assert property (@(posedge clock) disable iff (reset)
      back_stat.walking |-> !cmd_pop)
      else $error("command taken while a tick walks the store");

   a_range_error_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error_code == ERR_RANGE) |->
         (rsp_timer_status == ST_IDLE && rsp_remaining == '0))
      else $error("out-of-range response carries slot data");

   a_error_code_known: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_error_code == ERR_OK || rsp_error_code == ERR_RANGE ||
                      rsp_error_code == ERR_STATE))
      else $error("response carries an undefined error code");

endmodule

// File: test/timer_bank_checker.sv
module timer_bank_checker import gct_pkg::*; #(
   parameter int TIMER_SLOTS  = 128,
   parameter int MAX_CHANNELS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  logic [2:0]           req_kind,
   input  logic [2:0]           req_timer_group,
   input  logic [6:0]           req_channel,
   input  logic [SECS_W-1:0]    req_seconds,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  logic [1:0]           rsp_timer_status,
   input  logic [SECS_W-1:0]    rsp_remaining,
   input  logic [1:0]           rsp_error_code,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   output int                   mismatch_total,
   output int                   reports_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [SECS_W-1:0] time_left [TIMER_SLOTS];
   logic [1:0]        slot_state [TIMER_SLOTS];
   logic [CNT_W-1:0]  layout [4];
   rsp_type           timer_reports_q [$];
   int                fail_tally = 0;

   function automatic int clamp_count(logic [CNT_W-1:0] c);
      return (c > MAX_CHANNELS) ? MAX_CHANNELS : int'(c);
   endfunction

   function automatic int group_base(logic [2:0] grp);
      int v, si, so;
      v  = clamp_count(layout[REG_VIDEO]);
      si = clamp_count(layout[REG_SENSOR_IN]);
      so = clamp_count(layout[REG_SENSOR_OUT]);
      case (grp)
         GRP_REC_MOTION: return 0;
         GRP_REC_SENSOR: return v;
         GRP_MOTION:     return 2 * v;
         GRP_VIDEO_LOSS: return 3 * v;
         GRP_SENSOR_IN:  return 4 * v;
         // The buzzer shares its base with the sensor outputs.
         GRP_SENSOR_OUT, GRP_BUZZER: return 4 * v + si;
         default:        return 4 * v + si + so + 1;
      endcase
   endfunction

   function automatic int bank_size();
      int n;
      n = group_base(GRP_OTHER) + clamp_count(layout[REG_OTHER]);
      return (n > TIMER_SLOTS) ? TIMER_SLOTS : n;
   endfunction

   // Applies one request to the local copy of the bank and returns its report.
   function automatic rsp_type run_command(logic [2:0] kind, logic [2:0] grp,
                                           logic [6:0] chn, logic [SECS_W-1:0] secs);
      rsp_type    r;
      int         size, slot, i;
      logic       hit;
      logic [1:0] err;
      r    = '0;
      err  = ERR_OK;
      size = bank_size();
      slot = group_base(grp) + int'(chn);
      hit  = slot < size;
      if (kind > KIND_TICK) return r;
      if (kind == KIND_TICK) begin
         for (i = 0; i < size; i++) begin
            if (time_left[i] != 0 && slot_state[i] != ST_PAUSED)
               time_left[i] = time_left[i] - 1'b1;
            if (time_left[i] == 0 && slot_state[i] == ST_COUNTING)
               slot_state[i] = ST_EXPIRED;
         end
         if (hit) begin
            r.timer_status = slot_state[slot];
            r.remaining    = time_left[slot];
         end
         return r;
      end
      if (!hit) begin
         r.error_code = ERR_RANGE;
         return r;
      end
      case (kind)
         KIND_START: begin
            if (slot_state[slot] != ST_IDLE) err = ERR_STATE;
            else begin
               slot_state[slot] = ST_COUNTING;
               time_left[slot]  = secs;
            end
         end
         KIND_STOP: begin
            if (slot_state[slot] == ST_IDLE) err = ERR_STATE;
            else begin
               slot_state[slot] = ST_IDLE;
               time_left[slot]  = '0;
            end
         end
         KIND_PAUSE: begin
            if (slot_state[slot] == ST_IDLE) err = ERR_STATE;
            else slot_state[slot] = ST_PAUSED;
         end
         KIND_SET: time_left[slot] = secs;
         default: ;
      endcase
      r.timer_status = slot_state[slot];
      r.remaining    = time_left[slot];
      r.error_code   = err;
      return r;
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            time_left[i]  = '0;
            slot_state[i] = ST_IDLE;
         end
         for (int i = 0; i < 4; i++) layout[i] = CNT_RESET;
         timer_reports_q.delete();
      end else begin
         if (csr_valid && csr_ready) layout[csr_index] = csr_wdata;
         // Responses are checked before this edge's request is predicted, so a
         // response cannot be matched against a request accepted at the same edge.
         if (rsp_pop && !rsp_empty) begin
            if (timer_reports_q.size() == 0) begin
               $error("response with no request waiting: status %0d remaining %0d error %0d",
                      rsp_timer_status, rsp_remaining, rsp_error_code);
               fail_tally++;
            end else begin
               want = timer_reports_q.pop_front();
               compare_field("timer_status", want.timer_status, rsp_timer_status);
               compare_field("remaining", want.remaining, rsp_remaining);
               compare_field("error_code", want.error_code, rsp_error_code);
            end
         end
         if (req_push && !req_full)
            timer_reports_q.push_back(run_command(req_kind, req_timer_group,
                                                  req_channel, req_seconds));
      end
      mismatch_total  <= fail_tally;
      reports_waiting <= timer_reports_q.size();
   end

endmodule

// File: test/grouped_countdown_timer_bank_tb.sv
module grouped_countdown_timer_bank_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gct_pkg::*;

   localparam int TIMER_SLOTS    = 128;
   localparam int MAX_CHANNELS   = 16;
   localparam int IDLE_PCT       = 24;
   localparam int HOLD_OFF       = 400;
   localparam int HOLD_AT        = 400;
   localparam int STEADY_FROM    = 900;
   localparam int STEADY_TO      = 1100;
   localparam int DRAIN_AT       = 1300;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic [2:0]           req_kind;
   logic [2:0]           req_timer_group;
   logic [6:0]           req_channel;
   logic [SECS_W-1:0]    req_seconds;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic [1:0]           rsp_timer_status;
   logic [SECS_W-1:0]    rsp_remaining;
   logic [1:0]           rsp_error_code;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_wdata;

   int mismatch_total;
   int reports_waiting;
   int sent = 0;
   int quiet = 0;

   grouped_countdown_timer_bank #(
      .TIMER_SLOTS(TIMER_SLOTS),
      .MAX_CHANNELS(MAX_CHANNELS)
   ) dut (.*);

   timer_bank_checker #(
      .TIMER_SLOTS(TIMER_SLOTS),
      .MAX_CHANNELS(MAX_CHANNELS)
   ) bank_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic offer(input logic [2:0] kind, input logic [2:0] grp,
                        input logic [6:0] chn, input logic [SECS_W-1:0] secs);
      bit steady;
      steady = sent >= STEADY_FROM && sent < STEADY_TO;
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_kind        <= kind;
      req_timer_group <= grp;
      req_channel     <= chn;
      req_seconds     <= secs;
      req_push        <= 1'b1;
      do @(posedge clock); while (req_full);
   endtask

   // The waiting count is a registered copy of the checker's queue size, so it is
   // trusted only from the next edge on.
   task automatic drain_requests();
      req_push <= 1'b0;
      @(posedge clock);
      while (reports_waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_layout(input logic [CNT_W-1:0] v, input logic [CNT_W-1:0] si,
                               input logic [CNT_W-1:0] so, input logic [CNT_W-1:0] oa);
      drain_requests();
      csr_write(REG_VIDEO, v);
      csr_write(REG_SENSOR_IN, si);
      csr_write(REG_SENSOR_OUT, so);
      csr_write(REG_OTHER, oa);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Small channels keep hitting the same few slots, and small times let ticks
   // carry them through to expiry.
   task automatic offer_random(output bit counted);
      logic [2:0]        kind;
      logic [6:0]        chn;
      logic [SECS_W-1:0] secs;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 18) kind = KIND_START;
      else if (pick < 28) kind = KIND_STOP;
      else if (pick < 38) kind = KIND_PAUSE;
      else if (pick < 48) kind = KIND_SET;
      else if (pick < 62) kind = KIND_CHECK;
      else if (pick < 93) kind = KIND_TICK;
      else kind = $urandom_range(1) ? KIND_UNUSED_HI : KIND_UNUSED_LO;
      pick = $urandom_range(99);
      if (pick < 70) chn = 7'($urandom_range(3));
      else if (pick < 85) chn = 7'($urandom_range(17));
      else chn = 7'($urandom_range(127));
      pick = $urandom_range(99);
      if (pick < 60) secs = SECS_W'($urandom_range(4));
      else if (pick < 85) secs = SECS_W'($urandom_range(16'hFFFF));
      else secs = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      offer(kind, 3'($urandom_range(7)), chn, secs);
      counted = kind <= KIND_TICK;
   endtask

   task automatic run_random(input int n);
      int issued;
      bit counted;
      issued = 0;
      while (issued < n) begin
         offer_random(counted);
         if (counted) begin
            issued++;
            sent++;
            if (sent == DRAIN_AT) drain_requests();
         end
      end
   endtask

   // With the reset layout the bases are 0, 16, 32, 48, 64, 80, 80, 97 and the
   // bank holds 113 slots.
   task automatic run_directed();
      offer(KIND_START, GRP_REC_MOTION, 7'd0, 16'hFFFF);
      offer(KIND_START, GRP_REC_MOTION, 7'd0, 16'h1234);
      offer(KIND_PAUSE, GRP_REC_MOTION, 7'd0, 16'h0000);
      offer(KIND_TICK, GRP_REC_MOTION, 7'd0, 16'h0000);
      offer(KIND_SET, GRP_REC_MOTION, 7'd0, 16'h0000);
      offer(KIND_STOP, GRP_REC_MOTION, 7'd0, 16'h0000);
      offer(KIND_STOP, GRP_REC_MOTION, 7'd0, 16'h0000);
      offer(KIND_PAUSE, GRP_REC_MOTION, 7'd0, 16'h0000);
      offer(KIND_START, GRP_OTHER, 7'd15, 16'd1);
      offer(KIND_TICK, GRP_OTHER, 7'd15, 16'hFFFF);
      offer(KIND_CHECK, GRP_OTHER, 7'd16, 16'h0000);
      offer(KIND_START, GRP_SENSOR_OUT, 7'd0, 16'd2);
      offer(KIND_CHECK, GRP_BUZZER, 7'd0, 16'h0000);
      offer(KIND_SET, GRP_REC_SENSOR, 7'd5, 16'd3);
      offer(KIND_TICK, GRP_OTHER, 7'd127, 16'h0000);
      offer(KIND_START, GRP_VIDEO_LOSS, 7'd3, 16'h0000);
      offer(KIND_TICK, GRP_VIDEO_LOSS, 7'd3, 16'h0000);
      offer(KIND_UNUSED_LO, GRP_OTHER, 7'd127, 16'hFFFF);
      offer(KIND_UNUSED_HI, GRP_OTHER, 7'd127, 16'hFFFF);
      offer(KIND_CHECK, GRP_REC_SENSOR, 7'd5, 16'h0000);
      offer(KIND_START, GRP_MOTION, 7'd127, 16'd7);
      offer(KIND_STOP, GRP_OTHER, 7'd15, 16'h0000);
      offer(KIND_PAUSE, GRP_SENSOR_IN, 7'd2, 16'h0000);
      offer(KIND_START, GRP_SENSOR_IN, 7'd2, 16'h8000);
      offer(KIND_CHECK, GRP_SENSOR_IN, 7'd2, 16'h0000);
   endtask

   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_kind        = '0;
      req_timer_group = '0;
      req_channel     = '0;
      req_seconds     = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(300);
      write_layout(5'd31, 5'd31, 5'd31, 5'd31);
      run_random(300);
      write_layout(5'd1, 5'd1, 5'd0, 5'd0);
      run_random(300);
      write_layout(5'd0, 5'd0, 5'd0, 5'd0);
      run_random(200);
      write_layout(CNT_W'($urandom_range(31)), CNT_W'($urandom_range(31)),
                   CNT_W'($urandom_range(31)), CNT_W'($urandom_range(31)));
      run_random(300);
      write_layout(CNT_RESET, CNT_RESET, CNT_RESET, CNT_RESET);
      run_random(400);
      req_push <= 1'b0;
      while (reports_waiting != 0) @(posedge clock);
      repeat (TIMER_SLOTS + 8) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Response side: random pops, one long hold-off while requests keep coming,
   // and a stretch that pops on every cycle.
   initial begin
      int  taken;
      bit  held;
      taken   = 0;
      held    = 1'b0;
      rsp_pop = 1'b0;
      forever begin
         if (!held && taken >= HOLD_AT) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end else begin
            rsp_pop <= (taken >= STEADY_FROM && taken < STEADY_TO) ||
                       $urandom_range(99) >= IDLE_PCT;
            @(posedge clock);
            if (rsp_pop && !rsp_empty) taken++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule

// File: sim.f
rtl/core/gct_pkg.sv
rtl/core/gct_queue.sv
rtl/core/gct_front.sv
rtl/core/gct_back.sv
rtl/core/grouped_countdown_timer_bank.sv
test/timer_bank_checker.sv
test/grouped_countdown_timer_bank_tb.sv
